[hdl/tfcal_pkg.sv]
// ---------------------------------------------------------------------------
// tfcal_pkg
// Shared widths, codes and helpers for the touch scan calibration block.
// ---------------------------------------------------------------------------
package tfcal_pkg;

   localparam int RAW_W      = 12;  // one raw conversion
   localparam int SUM_W      = 14;  // sum of four conversions
   localparam int DIFF_W     = 13;  // signed filtered value minus center
   localparam int MUL_W      = 10;  // scale numerator
   localparam int PROD_W     = 24;  // signed product
   localparam int MAG_W      = 23;  // product magnitude, quotient width
   localparam int DIV_W      = 17;  // signed denominator, also its magnitude
   localparam int POS_W      = 16;  // calibrated position
   localparam int HALF_W     = 12;  // half screen size
   localparam int TQ_W       = 25;  // signed quotient plus offset
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int CNT_W      = 5;   // divider step counter

   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef enum logic [1:0] {
      PEN_NONE = 2'd0,
      PEN_DOWN = 2'd1,
      PEN_HOLD = 2'd2,
      PEN_UP   = 2'd3
   } tfcal_pen_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_MUL_X    = 3'd2,
      CSR_MUL_Y    = 3'd3,
      CSR_DIV_X    = 3'd4,
      CSR_DIV_Y    = 3'd5
   } tfcal_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_START,
      ST_WAIT,
      ST_DONE
   } tfcal_state_type;

   typedef struct packed {
      logic load;    // capture the scan transaction
      logic mul;     // register both products
      logic start;   // launch both dividers
      logic commit;  // update held state and load the result register
   } tfcal_cmd_type;

   typedef struct packed {
      logic take;      // pen down before and after sampling
      logic div_done;  // quotients ready
   } tfcal_stat_type;

   // Trimmed mean of four samples: drop largest and smallest, halve the rest.
   function automatic logic [RAW_W-1:0] trim_mean(input logic [RAW_W-1:0] a,
                                                 input logic [RAW_W-1:0] b,
                                                 input logic [RAW_W-1:0] c,
                                                 input logic [RAW_W-1:0] d);
      logic [RAW_W-1:0] hi_ab, hi_cd, lo_ab, lo_cd, hi, lo;
      logic [SUM_W-1:0] sum, mid;
      hi_ab = (a > b) ? a : b;
      lo_ab = (a > b) ? b : a;
      hi_cd = (c > d) ? c : d;
      lo_cd = (c > d) ? d : c;
      hi    = (hi_ab > hi_cd) ? hi_ab : hi_cd;
      lo    = (lo_ab < lo_cd) ? lo_ab : lo_cd;
      sum   = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d);
      mid   = sum - SUM_W'(hi) - SUM_W'(lo);
      return mid[RAW_W:1];
   endfunction

endpackage

[hdl/tfcal_div.sv]
// ---------------------------------------------------------------------------
// tfcal_div
// Serial restoring divider on magnitudes, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tfcal_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tfcal_pkg::MAG_W-1:0] dividend,
   input  logic [tfcal_pkg::DIV_W-1:0] divisor,
   output logic [tfcal_pkg::MAG_W-1:0] quotient,
   output logic                      done
);
   import tfcal_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [DIV_W-1:0]    rem_ff;
   logic [MAG_W-1:0]    quo_ff;
   logic [DIV_W-1:0]    dsor_ff;

   logic [DIV_W:0]      shifted;
   logic [DIV_W:0]      trial;
   logic                fits;

   assign shifted = {rem_ff, quo_ff[MAG_W-1]};
   assign fits    = (shifted >= {1'b0, dsor_ff});
   assign trial   = shifted - {1'b0, dsor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= CNT_W'(MAG_W - 1);
         rem_ff  <= '0;
         quo_ff  <= dividend;
         dsor_ff <= divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_ff <= {quo_ff[MAG_W-2:0], fits};
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

[hdl/tfcal_ctrl.sv]
// ---------------------------------------------------------------------------
// tfcal_ctrl
// Sequencer for one scan transaction and the result valid register.
// ---------------------------------------------------------------------------
module tfcal_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tfcal_pkg::tfcal_cmd_type  cmd,
   input  tfcal_pkg::tfcal_stat_type stat
);
   import tfcal_pkg::*;

   tfcal_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = stat.take ? ST_START : ST_DONE;
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (stat.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("result not presented after commit");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == ST_WAIT))
      else $error("divider finished outside wait state");

   a_div_not_instant: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !stat.div_done)
      else $error("divider finished one cycle after launch");

endmodule

[hdl/tfcal_dp.sv]
// ---------------------------------------------------------------------------
// tfcal_dp
// Filter, scale, divide and clamp datapath with held pen state and CSRs.
// ---------------------------------------------------------------------------
module tfcal_dp #(
   parameter logic [tfcal_pkg::HALF_W-1:0] HALF_X = 12'd160,
   parameter logic [tfcal_pkg::HALF_W-1:0] HALF_Y = 12'd120
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tfcal_pkg::tfcal_cmd_type         cmd,
   output tfcal_pkg::tfcal_stat_type        stat,
   input  logic                             req_pen_before,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_x_raw_a,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_x_raw_b,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_x_raw_c,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_x_raw_d,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_y_raw_a,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_y_raw_b,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_y_raw_c,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_y_raw_d,
   input  logic                             req_pen_after,
   input  logic                             csr_write,
   input  logic [tfcal_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tfcal_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [tfcal_pkg::POS_W-1:0]      rsp_pos_x,
   output logic [tfcal_pkg::POS_W-1:0]      rsp_pos_y,
   output tfcal_pkg::tfcal_pen_type         rsp_pen_status,
   output logic                             rsp_pos_updated
);
   import tfcal_pkg::*;

   // configuration
   logic [RAW_W-1:0]  center_x_ff, center_y_ff;
   logic [MUL_W-1:0]  mul_x_ff, mul_y_ff;
   logic [DIV_W-1:0]  div_x_ff, div_y_ff;

   // captured transaction
   logic              before_ff, after_ff;
   logic [RAW_W-1:0]  v_x_ff, v_y_ff;

   // products
   logic signed [DIFF_W-1:0] diff_x, diff_y;
   logic signed [PROD_W-1:0] prod_x, prod_y;
   logic [PROD_W-1:0]        prod_x_ff, prod_y_ff;
   logic [PROD_W-1:0]        abs_x, abs_y;
   logic [DIV_W-1:0]         dabs_x, dabs_y;

   // dividers
   logic [MAG_W-1:0]  quo_x, quo_y;
   logic              done_x, done_y;

   // held state
   logic              pen_was_ff, pen_was_in;
   tfcal_pen_type     status_ff, status_in;
   logic [POS_W-1:0]  held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic              updated_in;

   // result register
   logic [POS_W-1:0]  out_x_ff, out_y_ff;
   tfcal_pen_type     out_status_ff;
   logic              out_updated_ff;

   logic [POS_W-1:0]  map_x, map_y;

   function automatic logic [POS_W-1:0] clamp_pos(input logic [MAG_W-1:0] q,
                                                 input logic neg,
                                                 input logic dzero,
                                                 input logic [HALF_W-1:0] half);
      logic [TQ_W-1:0] qs, t;
      qs = neg ? (~{2'b00, q} + 1'b1) : {2'b00, q};
      t  = qs + TQ_W'(half);
      if (dzero) begin
         return POS_MAX;
      end else if (t[TQ_W-1]) begin
         return '0;
      end else if (|t[TQ_W-2:POS_W]) begin
         return POS_MAX;
      end else begin
         return t[POS_W-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= RAW_W'(2048);
         center_y_ff <= RAW_W'(2048);
         mul_x_ff    <= MUL_W'(1);
         mul_y_ff    <= MUL_W'(1);
         div_x_ff    <= DIV_W'(1);
         div_y_ff    <= DIV_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata[RAW_W-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_wdata[RAW_W-1:0];
            CSR_MUL_X:    mul_x_ff    <= csr_wdata[MUL_W-1:0];
            CSR_MUL_Y:    mul_y_ff    <= csr_wdata[MUL_W-1:0];
            CSR_DIV_X:    div_x_ff    <= csr_wdata[DIV_W-1:0];
            CSR_DIV_Y:    div_y_ff    <= csr_wdata[DIV_W-1:0];
            default: ;
         endcase
      end
   end

   // filter at capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         before_ff <= req_pen_before;
         after_ff  <= req_pen_after;
         v_x_ff    <= trim_mean(req_x_raw_a, req_x_raw_b, req_x_raw_c, req_x_raw_d);
         v_y_ff    <= trim_mean(req_y_raw_a, req_y_raw_b, req_y_raw_c, req_y_raw_d);
      end
   end

   assign diff_x = $signed({1'b0, v_x_ff}) - $signed({1'b0, center_x_ff});
   assign diff_y = $signed({1'b0, v_y_ff}) - $signed({1'b0, center_y_ff});
   assign prod_x = diff_x * $signed({1'b0, mul_x_ff});
   assign prod_y = diff_y * $signed({1'b0, mul_y_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_x_ff <= prod_x;
         prod_y_ff <= prod_y;
      end
   end

   assign abs_x  = prod_x_ff[PROD_W-1] ? (~prod_x_ff + 1'b1) : prod_x_ff;
   assign abs_y  = prod_y_ff[PROD_W-1] ? (~prod_y_ff + 1'b1) : prod_y_ff;
   assign dabs_x = div_x_ff[DIV_W-1] ? (~div_x_ff + 1'b1) : div_x_ff;
   assign dabs_y = div_y_ff[DIV_W-1] ? (~div_y_ff + 1'b1) : div_y_ff;

   tfcal_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .dividend (abs_x[MAG_W-1:0]),
      .divisor  (dabs_x),
      .quotient (quo_x),
      .done     (done_x)
   );

   tfcal_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .dividend (abs_y[MAG_W-1:0]),
      .divisor  (dabs_y),
      .quotient (quo_y),
      .done     (done_y)
   );

   assign stat.take     = before_ff & after_ff;
   assign stat.div_done = done_x;

   assign map_x = clamp_pos(quo_x, prod_x_ff[PROD_W-1] ^ div_x_ff[DIV_W-1],
                            (div_x_ff == '0), HALF_X);
   assign map_y = clamp_pos(quo_y, prod_y_ff[PROD_W-1] ^ div_y_ff[DIV_W-1],
                            (div_y_ff == '0), HALF_Y);

   always_comb begin
      pen_was_in = pen_was_ff;
      status_in  = status_ff;
      held_x_in  = held_x_ff;
      held_y_in  = held_y_ff;
      updated_in = 1'b0;
      if (before_ff && after_ff) begin
         held_x_in  = map_x;
         held_y_in  = map_y;
         status_in  = pen_was_ff ? PEN_HOLD : PEN_DOWN;
         pen_was_in = 1'b1;
         updated_in = 1'b1;
      end else if (!before_ff) begin
         status_in  = pen_was_ff ? PEN_UP : PEN_NONE;
         pen_was_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_was_ff <= 1'b0;
         status_ff  <= PEN_NONE;
         held_x_ff  <= POS_MAX;
         held_y_ff  <= POS_MAX;
      end else if (cmd.commit) begin
         pen_was_ff <= pen_was_in;
         status_ff  <= status_in;
         held_x_ff  <= held_x_in;
         held_y_ff  <= held_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_x_ff       <= held_x_in;
         out_y_ff       <= held_y_in;
         out_status_ff  <= status_in;
         out_updated_ff <= updated_in;
      end
   end

   assign rsp_pos_x       = out_x_ff;
   assign rsp_pos_y       = out_y_ff;
   assign rsp_pen_status  = out_status_ff;
   assign rsp_pos_updated = out_updated_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      done_x == done_y)
      else $error("axis dividers out of step");

   a_take_sets_pen: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && before_ff && after_ff) |=> pen_was_ff)
      else $error("pen flag not set after a full touch");

   a_lift_clears_pen: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !before_ff) |=> (!pen_was_ff && !out_updated_ff))
      else $error("pen flag or update flag wrong after pen up");

endmodule

[hdl/touch_filter_calibrate_pen_state.sv]
// ---------------------------------------------------------------------------
// touch_filter_calibrate_pen_state
// Resistive touch scan filter with linear calibration and pen status.
// ---------------------------------------------------------------------------
// Usage:
//  - req_*: one scan transaction: pen flags and four raw X and Y conversions.
//    Accepted on req_valid && req_ready; req_ready is high only while the
//    sequencer is idle, so one scan is processed at a time.
//  - rsp_*: one result transaction per scan: held X/Y position, pen status
//    and an updated flag. The result sits in an output register, so the
//    sequencer returns to idle and takes the next scan while it waits.
//  - csr_*: register writes, always ready; write only while idle.
// Sequence: a scan with the pen down throughout passes from accept to rsp_valid
// through capture, multiply, launch, 23 divider steps, finish and commit; the
// serial divider, one per axis, runs in parallel. Other scans go through
// capture, multiply and commit only. The next scan is accepted in the cycle
// after the commit.
// Reset: registers return to their defaults, held position to 0xFFFF,
// status to none. A stalled receiver holds the result; the block then
// finishes the next scan and waits before commit until the slot frees.
// ---------------------------------------------------------------------------
module touch_filter_calibrate_pen_state #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_pen_before,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_x_raw_a,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_x_raw_b,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_x_raw_c,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_x_raw_d,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_y_raw_a,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_y_raw_b,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_y_raw_c,
   input  logic [tfcal_pkg::RAW_W-1:0]      req_y_raw_d,
   input  logic                             req_pen_after,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tfcal_pkg::POS_W-1:0]      rsp_pos_x,
   output logic [tfcal_pkg::POS_W-1:0]      rsp_pos_y,
   output logic [1:0]                       rsp_pen_status,
   output logic                             rsp_pos_updated,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tfcal_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tfcal_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tfcal_pkg::*;

   // Half screen offsets added after the divide.
   localparam logic [HALF_W-1:0] HALF_X = HALF_W'(SCREEN_WIDTH / 2);
   localparam logic [HALF_W-1:0] HALF_Y = HALF_W'(SCREEN_HEIGHT / 2);

   tfcal_cmd_type  cmd;
   tfcal_stat_type stat;
   tfcal_pen_type  pen_status;

   // Register writes never stall.
   assign csr_ready = 1'b1;

   tfcal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   tfcal_dp #(
      .HALF_X (HALF_X),
      .HALF_Y (HALF_Y)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_pen_before  (req_pen_before),
      .req_x_raw_a     (req_x_raw_a),
      .req_x_raw_b     (req_x_raw_b),
      .req_x_raw_c     (req_x_raw_c),
      .req_x_raw_d     (req_x_raw_d),
      .req_y_raw_a     (req_y_raw_a),
      .req_y_raw_b     (req_y_raw_b),
      .req_y_raw_c     (req_y_raw_c),
      .req_y_raw_d     (req_y_raw_d),
      .req_pen_after   (req_pen_after),
      .csr_write       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pen_status  (pen_status),
      .rsp_pos_updated (rsp_pos_updated)
   );

   // Drive the status code onto the plain two-bit port.
   assign rsp_pen_status = pen_status;

endmodule
